/* rtl/ppf_pkg.sv */
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared constants, configuration register codes and result type of the
// packet pattern filter.
// ----------------------------------------------------------------------------
package ppf_pkg;

  // Longest pattern, in bytes; also the number of window cells.
  localparam int MAX_PATTERN = 32;
  localparam int PAT_WORDS   = 4;
  localparam int WORD_W      = 64;
  localparam int BYTES_PER_W = WORD_W / 8;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int COUNT_W     = 16;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_WORD_0 = 3'd0,
    CFG_PATTERN_WORD_1 = 3'd1,
    CFG_PATTERN_WORD_2 = 3'd2,
    CFG_PATTERN_WORD_3 = 3'd3,
    CFG_PATTERN_LENGTH = 3'd4
  } ppf_cfg_e;

  typedef struct packed {
    logic               packet_matched;
    logic [COUNT_W-1:0] match_count;
    logic               batch_done;
  } ppf_result_t;

endpackage

/* rtl/packet_pattern_filter.sv */
// ----------------------------------------------------------------------------
// packet_pattern_filter
// Substring match filter over packet byte streams.
//
// Takes one input request per cycle while the result buffer has room. A byte
// shifts into a row of window cells; each cell compares the byte it takes
// with its pattern byte, so the whole window is checked in the cycle the
// byte arrives. A request carrying packet_end gives one result, which a
// two-entry output buffer registers; two results may wait there before
// the input stalls. Configuration writes are always accepted, with no
// stall, and must be made while no packet is in flight.
// ----------------------------------------------------------------------------
module packet_pattern_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ppf_pkg::WORD_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          byte_present_i,
  input  logic                          packet_end_i,
  input  logic                          batch_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          packet_matched_o,
  output logic [ppf_pkg::COUNT_W-1:0]   match_count_o,
  output logic                          batch_done_o
);
  import ppf_pkg::*;

  logic [WORD_W-1:0]  pat_word_q [PAT_WORDS];
  logic [LEN_W-1:0]   plen_q;
  logic [LEN_W-1:0]   len_eff;
  logic [7:0]         pat_bytes [MAX_PATTERN];
  logic [7:0]         win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq;

  logic [LEN_W-1:0]   seen_d, seen_q;
  logic               hit_d, hit_q;
  logic [COUNT_W-1:0] cnt_d, cnt_q, cnt_rep;
  logic               in_acc, shift, hit_now, matched, push;
  ppf_result_t        res, res_out;

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_word_q[w] <= '0;
      end
      plen_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PATTERN_WORD_0: pat_word_q[0] <= cfg_data_i;
        CFG_PATTERN_WORD_1: pat_word_q[1] <= cfg_data_i;
        CFG_PATTERN_WORD_2: pat_word_q[2] <= cfg_data_i;
        CFG_PATTERN_WORD_3: pat_word_q[3] <= cfg_data_i;
        CFG_PATTERN_LENGTH: plen_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = (plen_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : plen_q;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pat_bytes[j] = pat_word_q[j / BYTES_PER_W][8 * (j % BYTES_PER_W) +: 8];
    end
  end

  // ---------------- window cells ----------------
  assign in_acc = in_valid_i && in_ready_o;
  assign shift  = in_acc && byte_present_i;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0]       byte_in;
    logic [LEN_W-1:0] sel;

    if (k == 0) begin : g_head
      assign byte_in = data_byte_i;
    end else begin : g_body
      assign byte_in = win[k-1];
    end

    // newest byte lines up with the last pattern byte
    assign sel = len_eff - LEN_W'(k + 1);

    ppf_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift),
      .byte_i    (byte_in),
      .pat_byte_i(pat_bytes[sel[IDX_W-1:0]]),
      .active_i  (LEN_W'(k) < len_eff),
      .byte_o    (win[k]),
      .eq_o      (eq[k])
    );
  end

  // ---------------- packet and batch state ----------------
  always_comb begin
    seen_d = seen_q;
    if (shift && seen_q < LEN_W'(MAX_PATTERN)) begin
      seen_d = seen_q + LEN_W'(1);
    end
    hit_now = shift && (len_eff != '0) && (seen_d >= len_eff) && (&eq);
    hit_d   = hit_q || hit_now;
    matched = hit_d || (len_eff == '0);

    cnt_rep = cnt_q;
    if (matched && cnt_q != '1) begin
      cnt_rep = cnt_q + COUNT_W'(1);
    end

    push = in_acc && packet_end_i;
    cnt_d = cnt_q;
    if (push) begin
      seen_d = '0;
      hit_d  = 1'b0;
      cnt_d  = batch_end_i ? '0 : cnt_rep;
    end

    res.packet_matched = matched;
    res.match_count    = cnt_rep;
    res.batch_done     = batch_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      hit_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (in_acc) begin
      seen_q <= seen_d;
      hit_q  <= hit_d;
      cnt_q  <= cnt_d;
    end
  end

  // ---------------- result buffer ----------------
  ppf_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res_i      (res),
    .ready_o    (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign packet_matched_o = res_out.packet_matched;
  assign match_count_o    = res_out.match_count;
  assign batch_done_o     = res_out.batch_done;

  // ---------------- assertions ----------------
  a_window_takes_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |=> win[0] == $past(data_byte_i))
    else $error("window head did not take the byte");

  a_packet_state_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (seen_q == '0 && !hit_q))
    else $error("packet state not cleared at packet end");

  a_count_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !(packet_end_i && batch_end_i)) |=> cnt_q >= $past(cnt_q))
    else $error("match count wrapped");

  a_empty_pattern_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && len_eff == '0) |-> res.packet_matched)
    else $error("empty pattern did not match");

endmodule

/* rtl/ppf_cell.sv */
// ----------------------------------------------------------------------------
// ppf_cell
// One window cell: holds one recent byte, hands it to the next cell on each
// shift, and compares the byte it is about to take with its pattern byte.
// ----------------------------------------------------------------------------
module ppf_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_byte_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       eq_o
);

  logic [7:0] byte_d, byte_q;

  always_comb begin
    byte_d = shift_i ? byte_i : byte_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  // Unused cells beyond the pattern length never veto a match.
  assign eq_o   = !active_i || (byte_i == pat_byte_i);
  assign byte_o = byte_q;

endmodule

/* rtl/ppf_out_buf.sv */
// ----------------------------------------------------------------------------
// ppf_out_buf
// Two-entry result buffer: an output register plus a skid register, so the
// input side keeps moving while a result waits for the consumer.
// ----------------------------------------------------------------------------
module ppf_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ppf_pkg::ppf_result_t res_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ppf_pkg::ppf_result_t res_o
);
  import ppf_pkg::*;

  logic        out_valid_d, out_valid_q;
  logic        skid_valid_d, skid_valid_q;
  ppf_result_t out_d, out_q;
  ppf_result_t skid_d, skid_q;
  logic        pop;

  assign pop = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!out_valid_q || (pop && !skid_valid_q)) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        // hold the result in the skid stage
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("result pushed into full buffer");

  a_skid_moves_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && skid_valid_q) |=> (out_valid_q && res_o == $past(skid_q)))
    else $error("skid entry not forwarded");

endmodule

/* tb/sv/packet_pattern_filter_checker.sv */
// ----------------------------------------------------------------------------
// packet_pattern_filter_checker
// Watches the configuration, input and result channels of the packet pattern
// filter, keeps its own model of the match window, and compares every result
// with the expected one, oldest first.
// ----------------------------------------------------------------------------
module packet_pattern_filter_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [ppf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ppf_pkg::WORD_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          byte_present_i,
  input  logic                          packet_end_i,
  input  logic                          batch_end_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          packet_matched_i,
  input  logic [ppf_pkg::COUNT_W-1:0]   match_count_i,
  input  logic                          batch_done_i,
  output int                            failures_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppf_pkg::*;

  logic [7:0]         window_q [MAX_PATTERN];
  int                 window_fill;
  logic               packet_hit_q;
  logic [COUNT_W-1:0] batch_count_q;
  logic [WORD_W-1:0]  pattern_q [PAT_WORDS];
  logic [LEN_W-1:0]   pattern_len_q;
  ppf_result_t        expected_results [$];
  int                 failures = 0;

  task automatic flag_error(input string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    failures++;
  endtask

  // Shift one request through the window model; a packet end yields a result.
  task automatic advance_filter(input logic [7:0] value, input logic present,
                                input logic pend, input logic bend);
    int          span;
    logic        hit_now;
    ppf_result_t outcome;
    span = (pattern_len_q > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_len_q);
    if (present) begin
      for (int k = MAX_PATTERN - 1; k > 0; k--) window_q[k] = window_q[k-1];
      window_q[0] = value;
      if (window_fill < MAX_PATTERN) window_fill++;
      if (span > 0 && window_fill >= span) begin
        hit_now = 1'b1;
        // pattern byte 0 lines up with the oldest of the last span bytes
        for (int i = 0; i < span; i++) begin
          if (window_q[span-1-i] !== pattern_q[i/BYTES_PER_W][8*(i%BYTES_PER_W) +: 8])
            hit_now = 1'b0;
        end
        if (hit_now) packet_hit_q = 1'b1;
      end
    end
    if (pend) begin
      outcome.packet_matched = packet_hit_q || span == 0;
      if (outcome.packet_matched && batch_count_q != '1) batch_count_q++;
      outcome.match_count = batch_count_q;
      outcome.batch_done  = bend;
      expected_results.push_back(outcome);
      window_fill  = 0;
      packet_hit_q = 1'b0;
      if (bend) batch_count_q = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    ppf_result_t expected;
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN; k++) window_q[k] = 8'h00;
      for (int w = 0; w < PAT_WORDS; w++) pattern_q[w] = '0;
      window_fill   = 0;
      packet_hit_q  = 1'b0;
      batch_count_q = '0;
      pattern_len_q = '0;
      expected_results.delete();
      failures_o <= failures;
      pending_o  <= 0;
    end else begin
      // check results first: a result never belongs to a request of this edge
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result with none expected: matched=%0b count=%0d done=%0b",
                               packet_matched_i, match_count_i, batch_done_i));
        end else begin
          expected = expected_results.pop_front();
          if (packet_matched_i !== expected.packet_matched)
            flag_error($sformatf("packet_matched: got %0b, expected %0b",
                                 packet_matched_i, expected.packet_matched));
          if (match_count_i !== expected.match_count)
            flag_error($sformatf("match_count: got %0d, expected %0d",
                                 match_count_i, expected.match_count));
          if (batch_done_i !== expected.batch_done)
            flag_error($sformatf("batch_done: got %0b, expected %0b",
                                 batch_done_i, expected.batch_done));
        end
      end
      // a request on this edge still sees the registers as they were
      if (in_valid_i && in_ready_i)
        advance_filter(data_byte_i, byte_present_i, packet_end_i, batch_end_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (ppf_cfg_e'(cfg_index_i))
          CFG_PATTERN_WORD_0: pattern_q[0] = cfg_data_i;
          CFG_PATTERN_WORD_1: pattern_q[1] = cfg_data_i;
          CFG_PATTERN_WORD_2: pattern_q[2] = cfg_data_i;
          CFG_PATTERN_WORD_3: pattern_q[3] = cfg_data_i;
          CFG_PATTERN_LENGTH: pattern_len_q = cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      failures_o <= failures;
      pending_o  <= expected_results.size();
    end
  end

endmodule

/* tb/sv/packet_pattern_filter_test.sv */
// ----------------------------------------------------------------------------
// packet_pattern_filter_test
// Drives packets through the pattern filter under several pattern settings:
// a directed opening, then random packets that embed, break or miss the
// pattern.
// ----------------------------------------------------------------------------
module packet_pattern_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppf_pkg::*;

  localparam int STALL_LIMIT      = 5000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int RANDOM_ITEMS     = 400;
  localparam int STAGES           = 9;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           data_byte;
  logic                 byte_present;
  logic                 packet_end;
  logic                 batch_end;
  logic                 out_valid;
  logic                 out_ready;
  logic                 packet_matched;
  logic [COUNT_W-1:0]   match_count;
  logic                 batch_done;

  int         failures;
  int         pending;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         stall_cycles = 0;
  int         items_sent = 0;
  logic [7:0] pat_bytes [MAX_PATTERN];
  int         pat_len;

  packet_pattern_filter dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_byte_i      (data_byte),
    .byte_present_i   (byte_present),
    .packet_end_i     (packet_end),
    .batch_end_i      (batch_end),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .packet_matched_o (packet_matched),
    .match_count_o    (match_count),
    .batch_done_o     (batch_done)
  );

  packet_pattern_filter_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .data_byte_i      (data_byte),
    .byte_present_i   (byte_present),
    .packet_end_i     (packet_end),
    .batch_end_i      (batch_end),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .packet_matched_i (packet_matched),
    .match_count_i    (match_count),
    .batch_done_i     (batch_done),
    .failures_o       (failures),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Valid stays high from one request to the next unless a gap is rolled.
  task automatic send_item(input logic [7:0] value, input logic present,
                           input logic pend, input logic bend);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    data_byte    <= value;
    byte_present <= present;
    packet_end   <= pend;
    batch_end    <= bend;
    do @(posedge clk); while (!in_ready);
    if (present || pend) items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input ppf_cfg_e idx, input logic [WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic logic [WORD_W-1:0] pattern_word(input int w);
    logic [WORD_W-1:0] word;
    for (int b = 0; b < BYTES_PER_W; b++) word[8*b +: 8] = pat_bytes[BYTES_PER_W*w + b];
    return word;
  endfunction

  // Load pat_bytes and a length once the filter has gone quiet.
  task automatic write_pattern(input int len_value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_PATTERN_WORD_0, pattern_word(0));
    write_reg(CFG_PATTERN_WORD_1, pattern_word(1));
    write_reg(CFG_PATTERN_WORD_2, pattern_word(2));
    write_reg(CFG_PATTERN_WORD_3, pattern_word(3));
    write_reg(CFG_PATTERN_LENGTH, WORD_W'(len_value));
    cfg_valid <= 1'b0;
    pat_len = (len_value > MAX_PATTERN) ? MAX_PATTERN : len_value;
  endtask

  task automatic randomize_pattern(input bit narrow);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (!narrow)
        pat_bytes[i] = 8'($urandom_range(0, 255));
      else
        case ($urandom_range(0, 2))
          0:       pat_bytes[i] = 8'h00;
          1:       pat_bytes[i] = 8'hFF;
          default: pat_bytes[i] = 8'h5A;
        endcase
    end
  endtask

  // Send bytes as one packet; the end rides on the last byte or comes alone.
  task automatic send_packet(input logic [7:0] bytes [$], input bit bend,
                             input bit separate_end);
    bit last;
    if (bytes.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, bend);
    end else begin
      for (int i = 0; i < bytes.size(); i++) begin
        // drop in an idle request or a stray batch end now and then
        if ($urandom_range(0, 24) == 0)
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
        last = (i == bytes.size() - 1) && !separate_end;
        send_item(bytes[i], 1'b1, last, last && bend);
      end
      if (separate_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, bend);
    end
  endtask

  task automatic send_random_packet();
    logic [7:0] bytes [$];
    int         kind;
    int         lead;
    int         tail;
    int         cut;
    kind = $urandom_range(0, 9);
    lead = $urandom_range(0, 5);
    tail = $urandom_range(0, 5);
    case (kind)
      0, 1, 2, 3, 4, 5: begin
        repeat (lead) bytes.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < pat_len; i++) bytes.push_back(pat_bytes[i]);
        repeat (tail) bytes.push_back(8'($urandom_range(0, 255)));
        // spoil one pattern bit for a near miss
        if (kind == 5 && pat_len > 0) begin
          cut = lead + $urandom_range(0, pat_len - 1);
          bytes[cut] = bytes[cut] ^ (8'h01 << $urandom_range(0, 7));
        end
      end
      6: begin
        cut = (pat_len > 0) ? $urandom_range(0, pat_len - 1) : 0;
        for (int i = 0; i < cut; i++) bytes.push_back(pat_bytes[i]);
      end
      7: begin
        repeat ($urandom_range(0, 12))
          bytes.push_back(pat_bytes[$urandom_range(0, (pat_len > 0) ? pat_len - 1 : 0)]);
      end
      8: begin
        repeat ($urandom_range(0, 40)) bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    send_packet(bytes, $urandom_range(0, 5) == 0, $urandom_range(0, 4) == 0);
  endtask

  initial begin
    int stage_len [STAGES];
    int goal;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_PATTERN_WORD_0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    data_byte     = 8'h00;
    byte_present  = 1'b0;
    packet_end    = 1'b0;
    batch_end     = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 74;
    pat_len       = 0;
    stage_len     = '{1, 32, 0, 2, 63, 5, 8, 17, 3};
    rst_n         = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zero length after reset: an empty packet matches
    send_item(8'h00, 1'b0, 1'b1, 1'b1);
    // stray batch end and an idle request change nothing
    send_item(8'hFF, 1'b1, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);

    randomize_pattern(1'b0);
    pat_bytes[0] = 8'hA5;
    pat_bytes[1] = 8'h00;
    pat_bytes[2] = 8'hFF;
    write_pattern(3);
    // shorter than the pattern: no hit
    send_item(8'hA5, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(8'h11, 1'b1, 1'b0, 1'b0);
    send_item(8'hA5, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1, 1'b1);

    pat_bytes[0] = 8'hFF;
    write_pattern(1);
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1, 1'b0);

    // length above the window clamps to the full window
    write_pattern(40);
    send_item(8'h00, 1'b0, 1'b1, 1'b0);
    send_item(pat_bytes[0], 1'b1, 1'b1, 1'b1);

    for (int stage = 0; stage < STAGES; stage++) begin
      if (stage == 3) begin
        send_idle_pct = 74;
        recv_idle_pct <= 20;
      end
      if (stage == 6) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      randomize_pattern($urandom_range(0, 1));
      write_pattern(stage_len[stage]);
      goal = items_sent + RANDOM_ITEMS / STAGES;
      while (items_sent < goal) begin
        send_random_packet();
        // hold until every result is back
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
